FILE: src/inclusive_l2_sharer_directory_macros.svh
// Assertion macros used by the checker.
`ifndef INCLUSIVE_L2_SHARER_DIRECTORY_MACROS_SVH
`define INCLUSIVE_L2_SHARER_DIRECTORY_MACROS_SVH

// same-cycle implication
`define ISD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ISD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/isd_pkg.sv
`default_nettype none
package isd_pkg;

  localparam int ADDR_W    = 48;
  localparam int ACT_W     = 3;
  localparam int CORE_W    = 3;
  localparam int MAX_CORES = 8;

  localparam logic [ACT_W-1:0] ACT_RD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_OWN   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAN = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIRTY = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REPLY = 3'd4;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_INV   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_E = 2'd1;
  localparam logic [1:0] ST_M = 2'd2;

  typedef enum logic [1:0] {
    P_IDLE, P_RDQ, P_OWQ, P_VICQ
  } pend_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CORE_W-1:0] target;
    logic [ADDR_W-1:0] addr;
    logic              hit;
    logic              query_made;
    logic              query_clean;
    logic              victim;
    logic              victim_query;
    logic              victim_query_clean;
    logic              victim_clean;
    logic              grant_exclusive;
    logic              last;
  } res_t;

  // lowest set bit of a core mask
  function automatic logic [CORE_W-1:0] low_bit(input logic [MAX_CORES-1:0] m);
    logic [CORE_W-1:0] r;
    r = '0;
    for (int c = MAX_CORES - 1; c >= 0; c--) begin
      if (m[c]) r = CORE_W'(c);
    end
    return r;
  endfunction

  function automatic logic one_hot(input logic [MAX_CORES-1:0] m);
    return (m != '0) && ((m & (m - 8'd1)) == '0);
  endfunction

endpackage
`default_nettype wire

FILE: src/inclusive_l2_sharer_directory.sv
`default_nettype none
// Tag and sharer directory of an inclusive set-associative L2 shared by
// several L1 caches.
// Request channel: a request (action, requester, address, reply_dirty) is
// taken at a rising edge with start_i high and busy_o low.
// Result channel: each result is shown for one cycle with strobe_o high;
// the receiver cannot stall, so no result is ever held back.
// Timing: a request that completes without snoops is evaluated in S_EVAL
// and its result is registered there; the next request can be taken in
// the cycle that result is shown. Set read plus update/write back of the
// single directory RAM row keeps requests from overlapping. A request that
// invalidates L1 copies shows one invalidate per cycle, then the done result.
// A snoop query leaves busy_o low; the block then accepts only a snoop
// reply (anything else gives an error result), which finishes the request.
// Malformed requests give an error result in the next cycle.
// Reset: after rst_ni releases, the RAM is swept one set per cycle to mark
// every line invalid; busy_o stays high meanwhile.
// Accesses to the RAM never overlap: busy_o holds off the next read until
// the previous write back is done.
module inclusive_l2_sharer_directory #(
  parameter int SETS       = 4096,
  parameter int WAYS       = 12,
  parameter int LINE_BYTES = 64,
  parameter int CORES      = 8,
  parameter int ADDR_BITS  = 48
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [isd_pkg::ACT_W-1:0]  action_i,
  input  wire logic [isd_pkg::CORE_W-1:0] requester_i,
  input  wire logic [isd_pkg::ADDR_W-1:0] address_i,
  input  wire logic                       reply_dirty_i,
  output logic                            strobe_o,
  output logic [1:0]                      kind_o,
  output logic [isd_pkg::CORE_W-1:0]      target_core_o,
  output logic [isd_pkg::ADDR_W-1:0]      address_out_o,
  output logic                            hit_o,
  output logic                            query_made_o,
  output logic                            query_clean_o,
  output logic                            victim_o,
  output logic                            victim_query_o,
  output logic                            victim_query_clean_o,
  output logic                            victim_clean_o,
  output logic                            grant_exclusive_o,
  output logic                            last_o
);
  import isd_pkg::*;

  localparam int OFF   = $clog2(LINE_BYTES);
  localparam int SETB  = $clog2(SETS);
  localparam int TAG_W = ADDR_W - OFF - SETB;
  localparam int RK_W  = $clog2(WAYS);
  localparam int WAY_W = $clog2(WAYS);
  localparam int WAYB  = TAG_W + 2 + CORES + RK_W;
  localparam int ROW_W = WAYS * WAYB;
  localparam int AB    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] AMASK = {ADDR_W{1'b1}} >> (ADDR_W - AB);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EVAL, S_EMIT, S_WAIT
  } state_e;

  state_e                state_q;
  logic [SETB-1:0]       clr_q;
  logic [ACT_W-1:0]      act_q;
  logic [CORE_W-1:0]     req_q;
  logic [ADDR_W-1:0]     addr_q;
  logic                  dirty_q, fin_q;
  pend_e                 pop_q;
  logic [WAY_W-1:0]      pway_q;
  logic [CORES-1:0]      inv_q;
  logic [ADDR_W-1:0]     inv_addr_q;
  res_t                  done_q, res_q;
  logic                  strobe_q;

  logic [ADDR_W-1:0]     addr_m;
  logic                  accept, bad_req, rd_en, we;
  logic [SETB-1:0]       raddr, waddr;
  logic [ROW_W-1:0]      rdata, wdata, up_row;
  res_t                  up_res, inv_res, err_res;
  logic [CORES-1:0]      up_inv;
  logic [ADDR_W-1:0]     up_inv_addr;
  pend_e                 up_pop;
  logic [WAY_W-1:0]      up_pway;
  logic [CORE_W-1:0]     inv_tgt;

  assign busy_o  = !(state_q == S_IDLE || state_q == S_WAIT);
  assign accept  = start_i && !busy_o;
  assign addr_m  = address_i & AMASK;
  assign bad_req = (action_i > ACT_DIRTY) || ({1'b0, requester_i} >= (CORE_W+1)'(CORES));

  // set read: new request in idle, pending set on a snoop reply
  always_comb begin
    rd_en = 1'b0;
    raddr = addr_m[OFF +: SETB];
    if (accept && state_q == S_IDLE && !bad_req) rd_en = 1'b1;
    if (accept && state_q == S_WAIT && action_i == ACT_REPLY) begin
      rd_en = 1'b1;
      raddr = addr_q[OFF +: SETB];
    end
  end

  assign we    = (state_q == S_CLEAR) || (state_q == S_EVAL);
  assign waddr = (state_q == S_CLEAR) ? clr_q : addr_q[OFF +: SETB];
  assign wdata = (state_q == S_CLEAR) ? '0 : up_row;

  isd_ram #(.DEPTH(SETS), .AW(SETB), .DW(ROW_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  isd_update #(
    .WAYS(WAYS), .CORES(CORES), .SETB(SETB), .OFF(OFF), .TAG_W(TAG_W),
    .RK_W(RK_W), .WAY_W(WAY_W), .ROW_W(ROW_W)
  ) u_update (
    .fin_i      (fin_q),
    .act_i      (act_q),
    .req_i      (req_q),
    .addr_i     (addr_q),
    .dirty_i    (dirty_q),
    .pop_i      (pop_q),
    .pway_i     (pway_q),
    .row_i      (rdata),
    .row_o      (up_row),
    .res_o      (up_res),
    .inv_o      (up_inv),
    .inv_addr_o (up_inv_addr),
    .pop_o      (up_pop),
    .pway_o     (up_pway)
  );

  assign inv_tgt = low_bit(MAX_CORES'(inv_q));

  always_comb begin
    inv_res = '0;
    inv_res.kind = KIND_INV;
    inv_res.target = inv_tgt;
    inv_res.addr = inv_addr_q;
  end

  // error answer: input address echoed, last set, all other status bits clear
  always_comb begin
    err_res = '0;
    err_res.kind = KIND_ERR;
    err_res.addr = addr_m;
    err_res.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      pop_q      <= P_IDLE;
      pway_q     <= '0;
      act_q      <= '0;
      req_q      <= '0;
      addr_q     <= '0;
      dirty_q    <= 1'b0;
      fin_q      <= 1'b0;
      strobe_q   <= 1'b0;
      inv_q      <= '0;
      inv_addr_q <= '0;
      done_q     <= '0;
      res_q      <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          strobe_q <= 1'b0;
          clr_q <= clr_q + SETB'(1);
          if (clr_q == SETB'(SETS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && bad_req) begin
            strobe_q <= 1'b1;
            res_q    <= err_res;
          end else if (accept) begin
            strobe_q <= 1'b0;
            act_q    <= action_i;
            req_q    <= requester_i;
            addr_q   <= addr_m;
            fin_q    <= 1'b0;
            state_q  <= S_EVAL;
          end else begin
            strobe_q <= 1'b0;
          end
        end
        S_WAIT: begin
          if (accept && action_i == ACT_REPLY) begin
            strobe_q <= 1'b0;
            dirty_q  <= reply_dirty_i;
            fin_q    <= 1'b1;
            state_q  <= S_EVAL;
          end else if (accept) begin
            strobe_q <= 1'b1;
            res_q    <= err_res;
          end else begin
            strobe_q <= 1'b0;
          end
        end
        S_EVAL: begin
          pop_q  <= up_pop;
          pway_q <= up_pway;
          if (up_pop != P_IDLE) begin
            strobe_q <= 1'b1;
            res_q    <= up_res;
            state_q  <= S_WAIT;
          end else if (up_inv != '0) begin
            strobe_q   <= 1'b0;
            inv_q      <= up_inv;
            inv_addr_q <= up_inv_addr;
            done_q     <= up_res;
            state_q    <= S_EMIT;
          end else begin
            strobe_q <= 1'b1;
            res_q    <= up_res;
            state_q  <= S_IDLE;
          end
        end
        S_EMIT: begin
          strobe_q <= 1'b1;
          if (inv_q != '0) begin
            res_q <= inv_res;
            inv_q <= inv_q & ~(CORES'(1) << inv_tgt);
          end else begin
            res_q   <= done_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          strobe_q <= 1'b0;
          state_q  <= S_IDLE;
        end
      endcase
    end
  end

  assign strobe_o             = strobe_q;
  assign kind_o               = res_q.kind;
  assign target_core_o        = res_q.target;
  assign address_out_o        = res_q.addr;
  assign hit_o                = res_q.hit;
  assign query_made_o         = res_q.query_made;
  assign query_clean_o        = res_q.query_clean;
  assign victim_o             = res_q.victim;
  assign victim_query_o       = res_q.victim_query;
  assign victim_query_clean_o = res_q.victim_query_clean;
  assign victim_clean_o       = res_q.victim_clean;
  assign grant_exclusive_o    = res_q.grant_exclusive;
  assign last_o               = res_q.last;
endmodule
`default_nettype wire

FILE: src/isd_ram.sv
`default_nettype none
module isd_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: src/isd_update.sv
`default_nettype none
// Set update: lookup, replacement, sharer and LRU changes of one row.
module isd_update #(
  parameter int WAYS  = 12,
  parameter int CORES = 8,
  parameter int SETB  = 12,
  parameter int OFF   = 6,
  parameter int TAG_W = 30,
  parameter int RK_W  = 4,
  parameter int WAY_W = 4,
  parameter int ROW_W = 12 * 44
) (
  input  wire logic                       fin_i,
  input  wire logic [isd_pkg::ACT_W-1:0]  act_i,
  input  wire logic [isd_pkg::CORE_W-1:0] req_i,
  input  wire logic [isd_pkg::ADDR_W-1:0] addr_i,
  input  wire logic                       dirty_i,
  input  wire isd_pkg::pend_e             pop_i,
  input  wire logic [WAY_W-1:0]           pway_i,
  input  wire logic [ROW_W-1:0]           row_i,
  output logic      [ROW_W-1:0]           row_o,
  output isd_pkg::res_t                   res_o,
  output logic      [CORES-1:0]           inv_o,
  output logic      [isd_pkg::ADDR_W-1:0] inv_addr_o,
  output isd_pkg::pend_e                  pop_o,
  output logic      [WAY_W-1:0]           pway_o
);
  import isd_pkg::*;

  localparam int WAYB = TAG_W + 2 + CORES + RK_W;

  logic [TAG_W-1:0] tg [WAYS];
  logic [1:0]       st [WAYS];
  logic [CORES-1:0] sh [WAYS];
  logic [RK_W-1:0]  rk [WAYS];
  logic [TAG_W-1:0] ntg [WAYS];
  logic [1:0]       nst [WAYS];
  logic [CORES-1:0] nsh [WAYS];
  logic [RK_W-1:0]  nrk [WAYS];

  logic [TAG_W-1:0] tag_in;
  logic [SETB-1:0]  set_in;
  logic [CORES-1:0] bit_r, m;
  logic             any_hit, any_inv, do_touch;
  logic [WAY_W-1:0] hw, iw, vw, tw;
  logic [RK_W:0]    oldr;
  logic [ADDR_W-1:0] this_la, vic_la;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tg[w] = row_i[w*WAYB +: TAG_W];
      st[w] = row_i[w*WAYB + TAG_W +: 2];
      sh[w] = row_i[w*WAYB + TAG_W + 2 +: CORES];
      rk[w] = row_i[w*WAYB + TAG_W + 2 + CORES +: RK_W];
    end
  end

  assign tag_in  = addr_i[ADDR_W-1 -: TAG_W];
  assign set_in  = addr_i[OFF +: SETB];
  assign bit_r   = CORES'(1) << req_i;
  assign this_la = {tag_in, set_in, {OFF{1'b0}}};

  // way searches
  always_comb begin
    any_hit = 1'b0;
    any_inv = 1'b0;
    hw = '0;
    iw = '0;
    vw = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (st[w] != ST_I && tg[w] == tag_in) begin
        any_hit = 1'b1;
        hw = WAY_W'(w);
      end
      if (st[w] == ST_I) begin
        any_inv = 1'b1;
        iw = WAY_W'(w);
      end
      // ranks of a full set are a permutation, so the oldest is unique
      if (rk[w] == RK_W'(WAYS - 1)) vw = WAY_W'(w);
    end
  end

  assign vic_la = {tg[vw], set_in, {OFF{1'b0}}};

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ntg[w] = tg[w];
      nst[w] = st[w];
      nsh[w] = sh[w];
    end
    res_o = '0;
    res_o.last = 1'b1;
    inv_o = '0;
    inv_addr_o = this_la;
    pop_o = P_IDLE;
    pway_o = pway_i;
    do_touch = 1'b0;
    tw = '0;
    m = '0;
    if (fin_i) begin
      tw = pway_i;
      do_touch = 1'b1;
      res_o.kind = KIND_DONE;
      if (pop_i == P_VICQ) begin
        res_o.addr = {tg[pway_i], set_in, {OFF{1'b0}}};
        res_o.victim = 1'b1;
        res_o.victim_query = 1'b1;
        res_o.victim_query_clean = !dirty_i;
        res_o.victim_clean = !(dirty_i || st[pway_i] == ST_M);
        res_o.grant_exclusive = 1'b1;
        ntg[pway_i] = tag_in;
        nst[pway_i] = ST_E;
        nsh[pway_i] = bit_r;
      end else begin
        if (dirty_i) nst[pway_i] = ST_M;
        if (pop_i == P_RDQ) begin
          nsh[pway_i] = sh[pway_i] | bit_r;
        end else begin
          nsh[pway_i] = bit_r;
          res_o.grant_exclusive = 1'b1;
        end
        res_o.hit = 1'b1;
        res_o.query_made = 1'b1;
        res_o.query_clean = !dirty_i;
      end
    end else if (act_i == ACT_CLEAN || act_i == ACT_DIRTY) begin
      m = sh[hw];
      res_o.kind = KIND_DONE;
      res_o.hit = 1'b1;
      if (!any_hit || (act_i == ACT_CLEAN && (m & bit_r) == '0) ||
          (act_i == ACT_DIRTY && m != bit_r)) begin
        res_o = '0;
        res_o.kind = KIND_ERR;
        res_o.addr = addr_i;
        res_o.last = 1'b1;
      end else if (act_i == ACT_CLEAN) begin
        nsh[hw] = m & ~bit_r;
      end else begin
        nsh[hw] = '0;
        nst[hw] = ST_M;
      end
    end else if (any_hit) begin
      m = sh[hw];
      tw = hw;
      do_touch = 1'b1;
      res_o.kind = KIND_DONE;
      res_o.hit = 1'b1;
      if (m == '0) begin
        nsh[hw] = bit_r;
        res_o.grant_exclusive = 1'b1;
      end else if (one_hot(MAX_CORES'(m))) begin
        if (act_i == ACT_RD || low_bit(MAX_CORES'(m)) != req_i) begin
          do_touch = 1'b0;
          res_o = '0;
          res_o.kind = KIND_QUERY;
          res_o.target = low_bit(MAX_CORES'(m));
          res_o.addr = this_la;
          res_o.last = 1'b1;
          pop_o = (act_i == ACT_RD) ? P_RDQ : P_OWQ;
          pway_o = hw;
        end else begin
          res_o.grant_exclusive = 1'b1;
        end
      end else if (act_i == ACT_RD) begin
        nsh[hw] = m | bit_r;
      end else begin
        inv_o = m & ~bit_r;
        nsh[hw] = bit_r;
        res_o.query_made = 1'b1;
        res_o.query_clean = 1'b1;
        res_o.grant_exclusive = 1'b1;
      end
    end else if (any_inv) begin
      tw = iw;
      do_touch = 1'b1;
      ntg[iw] = tag_in;
      nst[iw] = ST_E;
      nsh[iw] = bit_r;
      res_o.kind = KIND_DONE;
      res_o.grant_exclusive = 1'b1;
    end else begin
      m = sh[vw];
      if (one_hot(MAX_CORES'(m))) begin
        res_o.kind = KIND_QUERY;
        res_o.target = low_bit(MAX_CORES'(m));
        res_o.addr = vic_la;
        pop_o = P_VICQ;
        pway_o = vw;
      end else begin
        tw = vw;
        do_touch = 1'b1;
        inv_o = m;
        inv_addr_o = vic_la;
        res_o.kind = KIND_DONE;
        res_o.addr = vic_la;
        res_o.victim = 1'b1;
        res_o.victim_query = (m != '0);
        res_o.victim_query_clean = 1'b1;
        res_o.victim_clean = (st[vw] != ST_M);
        res_o.grant_exclusive = 1'b1;
        ntg[vw] = tag_in;
        nst[vw] = ST_E;
        nsh[vw] = bit_r;
      end
    end
  end

  // LRU touch of way tw, against the states before this update
  always_comb begin
    oldr = (st[tw] != ST_I) ? {1'b0, rk[tw]} : (RK_W+1)'(WAYS);
    for (int w = 0; w < WAYS; w++) begin
      nrk[w] = rk[w];
      if (do_touch) begin
        if (WAY_W'(w) == tw) begin
          nrk[w] = '0;
        end else if (st[w] != ST_I && {1'b0, rk[w]} < oldr) begin
          nrk[w] = rk[w] + RK_W'(1);
        end
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_o[w*WAYB +: WAYB] = {nrk[w], nsh[w], nst[w], ntg[w]};
    end
  end
endmodule
`default_nettype wire

FILE: src/isd_chk.sv
`default_nettype none
`include "inclusive_l2_sharer_directory_macros.svh"
module isd_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic       strobe_o,
  input wire logic [1:0] kind_o,
  input wire logic       last_o
);
  import isd_pkg::*;

  // only invalidates precede the final result
  `ISD_ASSERT_IMPL(a_nonlast_inv, clk_i, rst_ni, strobe_o && !last_o, kind_o == KIND_INV, "non-final")
  // an invalidate is always followed directly by another result
  `ISD_ASSERT_NEXT(a_inv_chain, clk_i, rst_ni, strobe_o && kind_o == KIND_INV, strobe_o, "inv gap")
  // a taken request either answers at once or keeps the block busy
  `ISD_ASSERT_NEXT(a_accept_prog, clk_i, rst_ni, start_i && !busy_o, strobe_o || busy_o, "dropped")
  // a snoop query leaves the block open for the reply
  `ISD_ASSERT_IMPL(a_query_open, clk_i, rst_ni, strobe_o && kind_o == KIND_QUERY, last_o && !busy_o, "busy")
endmodule

bind inclusive_l2_sharer_directory isd_chk u_isd_chk (.*);
`default_nettype wire

FILE: dv/tb_inclusive_l2_sharer_directory.sv
`default_nettype none
// Checks the L2 directory against a cycle-free prediction of its tags, line states,
// sharer masks and LRU ages. The random stimulus works on five sets, with one shared
// pool of 16 tags. This makes hits, fills, full sets and evictions common.
module tb_inclusive_l2_sharer_directory;
  timeunit 1ns;
  timeprecision 1ps;
  import isd_pkg::*;

  localparam int NSETS = 4096;
  localparam int NWAYS = 12;
  localparam int LINES = NSETS * NWAYS;
  localparam int CYCLE_LIMIT = 400000;

  // a request as the driver presents it
  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [CORE_W-1:0] req;
    logic [ADDR_W-1:0] addr;
    logic              dirty;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [ACT_W-1:0] action_i = '0;
  logic [CORE_W-1:0] requester_i = '0;
  logic [ADDR_W-1:0] address_i = '0;
  logic reply_dirty_i = 1'b0;
  logic busy_o, strobe_o;
  logic [1:0] kind_o;
  logic [CORE_W-1:0] target_core_o;
  logic [ADDR_W-1:0] address_out_o;
  logic hit_o, query_made_o, query_clean_o, victim_o, victim_query_o;
  logic victim_query_clean_o, victim_clean_o, grant_exclusive_o, last_o;

  inclusive_l2_sharer_directory dut (.*);

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------------------
  // Directory prediction: one entry per line (set * ways + way)
  // ------------------------------------------------------------------
  logic [29:0] dir_tag   [LINES];
  logic [1:0]  dir_state [LINES];
  logic [7:0]  dir_share [LINES];
  logic [3:0]  dir_age   [LINES];
  pend_e       wait_op;
  logic [CORE_W-1:0] wait_req;
  logic [ADDR_W-1:0] wait_addr;
  int          wait_way;

  res_t     expected_results[$];
  request_t request_q[$];
  int errors = 0, checked = 0, sent = 0, queries = 0, evictions = 0;
  int idle_pct = 0;

  function automatic res_t blank_result(logic [1:0] k);
    res_t r;
    r = '0;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] line_address(logic [29:0] tg, int set);
    return {tg, set[11:0], 6'd0};
  endfunction

  function automatic logic [CORE_W-1:0] first_sharer(logic [7:0] m);
    for (int c = 0; c < 8; c++) if (m[c]) return CORE_W'(c);
    return '0;
  endfunction

  // way holding the tag, or NWAYS on a miss
  function automatic int lookup_way(logic [ADDR_W-1:0] addr);
    int base;
    base = int'(addr[17:6]) * NWAYS;
    for (int w = 0; w < NWAYS; w++)
      if (dir_state[base + w] != ST_I && dir_tag[base + w] == addr[47:18]) return w;
    return NWAYS;
  endfunction

  // append one expected result
  task automatic expect_result(res_t r);
    expected_results = {expected_results, r};
  endtask

  // make a way most recently used; invalid ways keep no age
  task automatic age_set(int base, int w);
    int old;
    old = (dir_state[base + w] != ST_I) ? dir_age[base + w] : NWAYS;
    for (int x = 0; x < NWAYS; x++)
      if (x != w && dir_state[base + x] != ST_I && dir_age[base + x] < old)
        dir_age[base + x]++;
    dir_age[base + w] = 0;
  endtask

  task automatic install_line(int base, int w, logic [29:0] tg, logic [CORE_W-1:0] req);
    age_set(base, w);
    dir_tag[base + w] = tg;
    dir_state[base + w] = ST_E;
    dir_share[base + w] = 8'(1) << req;
  endtask

  task automatic error_result(logic [ADDR_W-1:0] addr);
    res_t r;
    r = blank_result(KIND_ERR);
    r.addr = addr;
    expect_result(r);
  endtask

  task automatic snoop_query(pend_e op, logic [CORE_W-1:0] req, logic [ADDR_W-1:0] addr,
                             int w, logic [CORE_W-1:0] tgt, logic [ADDR_W-1:0] saddr);
    res_t r;
    r = blank_result(KIND_QUERY);
    r.target = tgt;
    r.addr = saddr;
    wait_op = op; wait_req = req; wait_addr = addr; wait_way = w;
    queries++;
    expect_result(r);
  endtask

  task automatic invalidate(logic [CORE_W-1:0] tgt, logic [ADDR_W-1:0] saddr);
    res_t r;
    r = blank_result(KIND_INV);
    r.target = tgt;
    r.addr = saddr;
    r.last = 1'b0;
    expect_result(r);
  endtask

  // snoop reply arrives: finish the waiting request
  task automatic complete_snoop(logic dirty);
    int set, base, i;
    res_t r;
    set = int'(wait_addr[17:6]);
    base = set * NWAYS;
    i = base + wait_way;
    r = blank_result(KIND_DONE);
    if (wait_op == P_VICQ) begin
      r.addr = line_address(dir_tag[i], set);
      r.victim = 1'b1;
      r.victim_query = 1'b1;
      r.victim_query_clean = !dirty;
      r.victim_clean = !(dirty || dir_state[i] == ST_M);
      r.grant_exclusive = 1'b1;
      install_line(base, wait_way, wait_addr[47:18], wait_req);
    end else begin
      if (dirty) dir_state[i] = ST_M;
      if (wait_op == P_RDQ) begin
        dir_share[i] |= 8'(1) << wait_req;
      end else begin
        dir_share[i] = 8'(1) << wait_req;
        r.grant_exclusive = 1'b1;
      end
      r.hit = 1'b1;
      r.query_made = 1'b1;
      r.query_clean = !dirty;
      age_set(base, wait_way);
    end
    wait_op = P_IDLE;
    expect_result(r);
  endtask

  // expected results of one request, applied in acceptance order
  task automatic predict_request(request_t rq);
    int set, base, hw, v, i;
    logic [29:0] tg;
    logic [7:0] m, bit_r;
    logic [ADDR_W-1:0] la;
    res_t r;
    if (wait_op != P_IDLE) begin
      if (rq.act != ACT_REPLY) error_result(rq.addr);
      else complete_snoop(rq.dirty);
      return;
    end
    if (rq.act > ACT_DIRTY) begin
      error_result(rq.addr);
      return;
    end
    set = int'(rq.addr[17:6]);
    base = set * NWAYS;
    tg = rq.addr[47:18];
    la = line_address(tg, set);
    hw = lookup_way(rq.addr);
    bit_r = 8'(1) << rq.req;
    // releases
    if (rq.act == ACT_CLEAN || rq.act == ACT_DIRTY) begin
      if (hw == NWAYS) begin
        error_result(rq.addr);
        return;
      end
      m = dir_share[base + hw];
      if (rq.act == ACT_CLEAN) begin
        if ((m & bit_r) == 0) begin
          error_result(rq.addr);
          return;
        end
        dir_share[base + hw] = m & ~bit_r;
      end else begin
        if (m != bit_r) begin
          error_result(rq.addr);
          return;
        end
        dir_share[base + hw] = '0;
        dir_state[base + hw] = ST_M;
      end
      r = blank_result(KIND_DONE);
      r.hit = 1'b1;
      expect_result(r);
      return;
    end
    // read / ownership hit
    if (hw != NWAYS) begin
      i = base + hw;
      m = dir_share[i];
      r = blank_result(KIND_DONE);
      r.hit = 1'b1;
      if (m == 0) begin
        dir_share[i] = bit_r;
        r.grant_exclusive = 1'b1;
      end else if ($countones(m) == 1) begin
        if (rq.act == ACT_RD) begin
          snoop_query(P_RDQ, rq.req, rq.addr, hw, first_sharer(m), la);
          return;
        end
        if (first_sharer(m) != rq.req) begin
          snoop_query(P_OWQ, rq.req, rq.addr, hw, first_sharer(m), la);
          return;
        end
        r.grant_exclusive = 1'b1;
      end else if (rq.act == ACT_RD) begin
        dir_share[i] = m | bit_r;
      end else begin
        for (int c = 0; c < 8; c++)
          if (m[c] && c != int'(rq.req)) invalidate(CORE_W'(c), la);
        dir_share[i] = bit_r;
        r.query_made = 1'b1;
        r.query_clean = 1'b1;
        r.grant_exclusive = 1'b1;
      end
      age_set(base, hw);
      expect_result(r);
      return;
    end
    // miss: lowest free way first
    for (int w = 0; w < NWAYS; w++) begin
      if (dir_state[base + w] == ST_I) begin
        install_line(base, w, tg, rq.req);
        r = blank_result(KIND_DONE);
        r.grant_exclusive = 1'b1;
        expect_result(r);
        return;
      end
    end
    // full set: evict the oldest line
    v = 0;
    for (int w = 1; w < NWAYS; w++) if (dir_age[base + w] > dir_age[base + v]) v = w;
    i = base + v;
    la = line_address(dir_tag[i], set);
    m = dir_share[i];
    evictions++;
    if ($countones(m) == 1) begin
      snoop_query(P_VICQ, rq.req, rq.addr, v, first_sharer(m), la);
      return;
    end
    for (int c = 0; c < 8; c++) if (m[c]) invalidate(CORE_W'(c), la);
    r = blank_result(KIND_DONE);
    r.addr = la;
    r.victim = 1'b1;
    r.victim_query = (m != 0);
    r.victim_query_clean = 1'b1;
    r.victim_clean = (dir_state[i] != ST_M);
    r.grant_exclusive = 1'b1;
    install_line(base, v, tg, rq.req);
    expect_result(r);
  endtask

  task automatic enqueue(logic [2:0] act, logic [2:0] req, logic [47:0] addr, logic dirty);
    request_t rq;
    rq.act = act; rq.req = req; rq.addr = addr; rq.dirty = dirty;
    predict_request(rq);
    request_q = {request_q, rq};
  endtask

  // ------------------------------------------------------------------
  // Driver: presents requests at the falling edge, holds until taken
  // ------------------------------------------------------------------
  logic taken = 1'b0;
  always @(posedge clk_i) taken <= start_i && !busy_o;

  always @(negedge clk_i) begin
    if (rst_ni && (taken || !start_i)) begin
      if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        request_t rq;
        rq = request_q[0];
        request_q.delete(0);
        action_i <= rq.act;
        requester_i <= rq.req;
        address_i <= rq.addr;
        reply_dirty_i <= rq.dirty;
        start_i <= 1'b1;
        sent++;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: every strobe is checked against the oldest expectation
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t got, want;
    got = '{kind_o, target_core_o, address_out_o, hit_o, query_made_o, query_clean_o,
            victim_o, victim_query_o, victim_query_clean_o, victim_clean_o,
            grant_exclusive_o, last_o};
    if (rst_ni && strobe_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        checked++;
        if (got !== want) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %p", want);
          $display("  actual   %p", got);
          errors++;
        end
      end
    end
  end

  // watchdog; its limit leaves room for the clearing sweep after reset
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout: %0d results still outstanding", expected_results.size());
      $display("tb_inclusive_l2_sharer_directory failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  int          hot_set [5];
  logic [29:0] tag_pool [16];

  function automatic logic [47:0] pick_address();
    return {tag_pool[$urandom_range(15)], hot_set[$urandom_range(4)][11:0],
            6'($urandom_range(63))};
  endfunction

  task automatic random_request();
    logic [47:0] a;
    logic [2:0] rq, act;
    int roll, w;
    roll = $urandom_range(99);
    a = pick_address();
    rq = 3'($urandom_range(7));
    if (wait_op != P_IDLE) begin
      // mostly the reply; sometimes a stray request, which must be refused
      act = (roll < 88) ? ACT_REPLY : 3'($urandom_range(7));
      if (act != ACT_REPLY) act = (act == ACT_REPLY) ? ACT_RD : act;
      enqueue(act, rq, {$urandom, 16'($urandom)}, 1'($urandom));
      return;
    end
    if (roll < 40) act = ACT_RD;
    else if (roll < 65) act = ACT_OWN;
    else if (roll < 80) act = ACT_CLEAN;
    else if (roll < 92) act = ACT_DIRTY;
    else act = 3'($urandom_range(4, 7));
    // releases mostly come from a real sharer
    if ((act == ACT_CLEAN || act == ACT_DIRTY) && $urandom_range(9) < 7) begin
      w = lookup_way(a);
      if (w != NWAYS && dir_share[int'(a[17:6]) * NWAYS + w] != 0)
        rq = first_sharer(dir_share[int'(a[17:6]) * NWAYS + w]);
    end
    enqueue(act, rq, a, 1'($urandom));
  endtask

  task automatic drain();
    while (request_q.size() != 0 || start_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [47:0] a, b;
    int pct [4];
    for (int i = 0; i < LINES; i++) begin
      dir_state[i] = ST_I;
      dir_tag[i] = '0;
      dir_share[i] = '0;
      dir_age[i] = '0;
    end
    wait_op = P_IDLE; wait_req = '0; wait_addr = '0; wait_way = 0;
    hot_set[0] = 0;
    hot_set[1] = NSETS - 1;
    for (int s = 2; s < 5; s++) hot_set[s] = $urandom_range(1, NSETS - 2);
    tag_pool[0] = '0;
    tag_pool[15] = '1;
    for (int t = 1; t < 15; t++) tag_pool[t] = 30'($urandom);
    pct = '{0, 69, 0, 19};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: every hit and hit-snoop flavor on one line, releases, malformed requests
    a = {30'h2aaa_5555, 12'd5, 6'd0};
    b = {30'h1555_aaaa, 12'd5, 6'd63};
    enqueue(ACT_RD, 3'd0, 48'd0, 1'b0);          // fill at address zero
    enqueue(ACT_RD, 3'd7, '1, 1'b0);             // fill at top address
    enqueue(ACT_RD, 3'd0, a, 1'b0);              // miss, free way
    enqueue(ACT_RD, 3'd0, a, 1'b0);              // read hit, sole sharer is requester
    enqueue(ACT_OWN, 3'd1, a, 1'b0);             // stray request while waiting
    enqueue(ACT_REPLY, 3'd5, b, 1'b1);           // dirty reply
    enqueue(ACT_OWN, 3'd2, a, 1'b0);             // ownership, one other sharer
    enqueue(ACT_REPLY, 3'd0, a, 1'b0);
    enqueue(ACT_OWN, 3'd2, a, 1'b0);             // ownership by sole sharer
    enqueue(ACT_RD, 3'd3, a, 1'b0);
    enqueue(ACT_REPLY, 3'd0, a, 1'b0);           // clean reply, sharers {2,3}
    enqueue(ACT_RD, 3'd4, a, 1'b0);              // several sharers, no snoop
    enqueue(ACT_OWN, 3'd7, a, 1'b0);             // invalidates 2,3,4
    enqueue(ACT_CLEAN, 3'd7, a, 1'b0);
    enqueue(ACT_CLEAN, 3'd7, a, 1'b0);           // non-sharer release
    enqueue(ACT_RD, 3'd1, a, 1'b0);              // hit with no sharer
    enqueue(ACT_DIRTY, 3'd2, a, 1'b0);           // not the sole sharer
    enqueue(ACT_DIRTY, 3'd1, a, 1'b0);           // ok, line goes modified
    enqueue(ACT_CLEAN, 3'd1, b, 1'b0);           // release miss
    enqueue(ACT_REPLY, 3'd0, a, 1'b1);           // reply while idle
    enqueue(3'd7, 3'd6, a, 1'b0);                // illegal action
    enqueue(3'd5, 3'd3, b, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct = pct[p];
      for (int n = 0; n < 103; n++) random_request();
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked, %0d snoop queries, %0d evictions",
             sent, checked, queries, evictions);
    if (errors == 0) begin
      $display("tb_inclusive_l2_sharer_directory passed");
    end else begin
      $display("tb_inclusive_l2_sharer_directory failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
